// ===== rtl/dtrq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtrq_pkg
// Types and constants shared by the deadline task release queue modules.
// ----------------------------------------------------------------------------
package dtrq_pkg;

	localparam int ID_W       = 16;
	localparam int DELAY_W    = 32;
	localparam int STEP_W     = 16;
	localparam int COUNT_W    = 7;
	localparam int S_TDATA_W  = 48;   // task_id, delay_ms
	localparam int S_TUSER_W  = 1;    // operation
	localparam int M_TDATA_W  = 24;   // released_task, queued_count, pad
	localparam int M_TUSER_W  = 2;    // released, enqueue_rejected

	localparam logic [STEP_W-1:0] STEP_RESET = 16'd100;

	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load_item;    // capture the accepted item
		logic rd_head;      // read the earliest entry
		logic tick_update;  // release if due, advance time
		logic ins_start;    // start the insertion walk at the tail
		logic ins_shift;    // move one later entry up a slot
		logic ins_write;    // place the new entry
		logic out_load;     // load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic pos_zero;
		logic shift_needed;
		logic due;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/dtrq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtrq_ctrl
// Sequencer for the queue: accepts an item, runs the tick or insertion
// steps and hands the result to the output register.
// ----------------------------------------------------------------------------
module dtrq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic          op,
	input  wire dtrq_pkg::sts_t sts,
	output dtrq_pkg::cmd_t     cmd
);
	import dtrq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_RD,
		ST_TICK_UPD,
		ST_INS_RD,
		ST_INS_CMP,
		ST_RESULT
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:     cmd.load_item = s_tvalid;
			ST_TICK_RD:  cmd.rd_head = 1'b1;
			ST_TICK_UPD: cmd.tick_update = 1'b1;
			ST_INS_RD:   cmd.ins_start = 1'b1;
			ST_INS_CMP: begin
				if (sts.pos_zero || !sts.shift_needed) begin
					cmd.ins_write = 1'b1;
				end else begin
					cmd.ins_shift = 1'b1;
				end
			end
			ST_RESULT:   cmd.out_load = sts.out_free;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (op == OP_TICK) begin
							state_q <= ST_TICK_RD;
						end else if (sts.full) begin
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_INS_RD;
						end
					end
				end
				ST_TICK_RD:  state_q <= ST_TICK_UPD;
				ST_TICK_UPD: state_q <= ST_RESULT;
				ST_INS_RD:   state_q <= ST_INS_CMP;
				ST_INS_CMP: begin
					if (sts.pos_zero || !sts.shift_needed) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dtrq_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtrq_dpath
// Sorted ring of entries in a memory with one read and one write port,
// current time, step register and result register.
// ----------------------------------------------------------------------------
module dtrq_dpath #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_WIDTH  = 48
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [dtrq_pkg::STEP_W-1:0]  cfg_wdata,
	input  wire logic                         op,
	input  wire logic [dtrq_pkg::ID_W-1:0]    in_task_id,
	input  wire logic [dtrq_pkg::DELAY_W-1:0] in_delay_ms,
	input  wire dtrq_pkg::cmd_t               cmd,
	output dtrq_pkg::sts_t                    sts,
	input  wire logic                         m_tready,
	output logic                              m_tvalid,
	output logic                              out_released,
	output logic [dtrq_pkg::ID_W-1:0]         out_released_task,
	output logic                              out_enqueue_rejected,
	output logic [dtrq_pkg::COUNT_W-1:0]      out_queued_count
);
	import dtrq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = TIME_WIDTH + ID_W;
	localparam logic [CW:0]   DEPTH_EXT = (CW+1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

	function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] s;
		s = {{(CW+1-AW){1'b0}}, base} + {1'b0, off};
		if (s >= DEPTH_EXT) begin
			s = s - DEPTH_EXT;
		end
		return s[AW-1:0];
	endfunction

	logic [EW-1:0]         mem [QUEUE_DEPTH];
	logic [EW-1:0]         rd_q;
	logic [AW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         pos_q;
	logic [TIME_WIDTH-1:0] time_q;
	logic [STEP_W-1:0]     step_q;
	logic [TIME_WIDTH-1:0] new_dl_q;
	logic [ID_W-1:0]       task_q;
	logic                  rel_q;
	logic [ID_W-1:0]       rel_id_q;
	logic                  rej_q;
	logic                  m_tvalid_q;
	logic [COUNT_W-1:0]    cnt_out_q;
	logic                  rel_out_q;
	logic [ID_W-1:0]       rel_id_out_q;
	logic                  rej_out_q;

	logic [TIME_WIDTH:0]   dl_sum;
	logic [TIME_WIDTH-1:0] dl_sat;
	logic [TIME_WIDTH:0]   tm_sum;
	logic [TIME_WIDTH-1:0] tm_sat;
	logic [TIME_WIDTH-1:0] rd_dl;
	logic [ID_W-1:0]       rd_id;
	logic                  rd_en;
	logic [AW-1:0]         raddr;
	logic                  wr_en;
	logic [AW-1:0]         waddr;
	logic [EW-1:0]         wdata;
	logic [CW+COUNT_W-1:0] cnt_ext;

	// saturating adds: deadline on enqueue, time on tick
	assign dl_sum = {1'b0, time_q} + {{(TIME_WIDTH+1-DELAY_W){1'b0}}, in_delay_ms};
	assign dl_sat = dl_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : dl_sum[TIME_WIDTH-1:0];
	assign tm_sum = {1'b0, time_q} + {{(TIME_WIDTH+1-STEP_W){1'b0}}, step_q};
	assign tm_sat = tm_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : tm_sum[TIME_WIDTH-1:0];

	assign rd_dl = rd_q[EW-1:ID_W];
	assign rd_id = rd_q[ID_W-1:0];

	// the next read during the walk is one slot below the next slot to be filled
	always_comb begin
		rd_en = 1'b0;
		raddr = head_q;
		if (cmd.rd_head) begin
			rd_en = 1'b1;
		end else if (cmd.ins_start) begin
			rd_en = (count_q != '0);
			raddr = ring_idx(head_q, count_q - CW'(1));
		end else if (cmd.ins_shift) begin
			rd_en = (pos_q > CW'(1));
			raddr = ring_idx(head_q, pos_q - CW'(2));
		end
	end

	assign wr_en = cmd.ins_shift | cmd.ins_write;
	assign waddr = ring_idx(head_q, pos_q);
	assign wdata = cmd.ins_shift ? rd_q : {new_dl_q, task_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	assign sts.full         = (count_q == DEPTH_CNT);
	assign sts.pos_zero     = (pos_q == '0);
	assign sts.shift_needed = (rd_dl > new_dl_q);
	assign sts.due          = (count_q != '0) && (rd_dl <= time_q);
	assign sts.out_free     = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			pos_q      <= '0;
			time_q     <= '0;
			step_q     <= STEP_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
			if (cmd.ins_start) begin
				pos_q <= count_q;
			end else if (cmd.ins_shift) begin
				pos_q <= pos_q - CW'(1);
			end
			if (cmd.ins_write) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.tick_update && sts.due) begin
				count_q <= count_q - CW'(1);
				head_q  <= ring_idx(head_q, CW'(1));
			end
			if (cmd.tick_update) begin
				time_q <= tm_sat;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign cnt_ext = {{COUNT_W{1'b0}}, count_q};

	// working flags follow the item in hand; the result copy holds while it waits
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			task_q   <= in_task_id;
			new_dl_q <= dl_sat;
			rel_q    <= 1'b0;
			rel_id_q <= '0;
			rej_q    <= (op == OP_ENQUEUE) && sts.full;
		end
		if (cmd.tick_update && sts.due) begin
			rel_q    <= 1'b1;
			rel_id_q <= rd_id;
		end
		if (cmd.out_load) begin
			cnt_out_q    <= cnt_ext[COUNT_W-1:0];
			rel_out_q    <= rel_q;
			rel_id_out_q <= rel_id_q;
			rej_out_q    <= rej_q;
		end
	end

	assign m_tvalid             = m_tvalid_q;
	assign out_released         = rel_out_q;
	assign out_released_task    = rel_id_out_q;
	assign out_enqueue_rejected = rej_out_q;
	assign out_queued_count     = cnt_out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("entry count beyond queue depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_write |-> !sts.full)
		else $error("insert into a full queue");

	a_release_pops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_update && sts.due |=> count_q == $past(count_q) - CW'(1))
		else $error("release did not remove an entry");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_update |=> time_q >= $past(time_q))
		else $error("time went backwards");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten");
`endif

endmodule
`default_nettype wire

// ===== rtl/deadline_task_release_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_task_release_queue
// Deadline-ordered task queue with tick-driven release of due tasks.
// ----------------------------------------------------------------------------
// One item is handled at a time. A tick passes through ST_TICK_RD, which
// reads the earliest entry, and ST_TICK_UPD, which releases it if due and
// advances time, to ST_RESULT. An enqueue walks over the queued tasks whose
// deadline is later than the new one (up to QUEUE_DEPTH - 1): entries sit
// sorted in a ring memory, and the insertion walk moves one entry a cycle
// through its single read and single write port. A rejected enqueue goes
// straight to ST_RESULT. The input is ready again the cycle after the result
// is loaded. The result register lets the next item in while a result waits;
// a result still unread holds the following one back. Time and deadlines
// saturate at the largest TIME_WIDTH-bit value. queued_count shows the low 7
// bits of the task count.
module deadline_task_release_queue #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_WIDTH  = 48
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [dtrq_pkg::STEP_W-1:0]     cfg_wdata,  // tick_step_ms
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [dtrq_pkg::S_TDATA_W-1:0]  s_tdata,    // task_id, delay_ms
	input  wire logic [dtrq_pkg::S_TUSER_W-1:0]  s_tuser,    // operation
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [dtrq_pkg::M_TDATA_W-1:0]       m_tdata,    // released_task, queued_count
	output logic [dtrq_pkg::M_TUSER_W-1:0]       m_tuser     // released, enqueue_rejected
);
	import dtrq_pkg::*;

	cmd_t               cmd;
	sts_t               sts;
	logic               released;
	logic [ID_W-1:0]    released_task;
	logic               enqueue_rejected;
	logic [COUNT_W-1:0] queued_count;

	dtrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser[0]),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtrq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_dpath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_wdata            (cfg_wdata),
		.op                   (s_tuser[0]),
		.in_task_id           (s_tdata[ID_W-1:0]),
		.in_delay_ms          (s_tdata[ID_W+DELAY_W-1:ID_W]),
		.cmd                  (cmd),
		.sts                  (sts),
		.m_tready             (m_tready),
		.m_tvalid             (m_tvalid),
		.out_released         (released),
		.out_released_task    (released_task),
		.out_enqueue_rejected (enqueue_rejected),
		.out_queued_count     (queued_count)
	);

	assign m_tdata = {{(M_TDATA_W-ID_W-COUNT_W){1'b0}}, queued_count, released_task};
	assign m_tuser = {enqueue_rejected, released};

endmodule
`default_nettype wire

// ===== sim/release_queue_checker.sv =====
// ----------------------------------------------------------------------------
// release_queue_checker
// Watches the item, result and register ports of the deadline task release
// queue, predicts each result from its own copy of time, step and the sorted
// task list, and compares results field by field in transfer order.
// ----------------------------------------------------------------------------
module release_queue_checker
	import dtrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_WIDTH  = 48
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [STEP_W-1:0]     cfg_wdata,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,    // task_id, delay_ms
	input  wire logic [S_TUSER_W-1:0]  s_tuser,    // operation
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [M_TDATA_W-1:0]  m_tdata,    // released_task, queued_count, pad
	input  wire logic [M_TUSER_W-1:0]  m_tuser,    // released, enqueue_rejected
	output int                         errors,
	output int                         outstanding
);

	typedef struct packed {
		logic               released;
		logic [ID_W-1:0]    task_id;
		logic               rejected;
		logic [COUNT_W-1:0] count;
	} release_result_t;

	typedef struct packed {
		logic [TIME_WIDTH-1:0] deadline;
		logic [ID_W-1:0]       task_id;
	} queued_task_t;

	logic [TIME_WIDTH-1:0] now_ms;
	logic [STEP_W-1:0]     step_ms;
	queued_task_t          waiting[$];    // earliest deadline first
	release_result_t       results[$];

	initial errors = 0;
	initial outstanding = 0;

	function automatic logic [TIME_WIDTH-1:0] add_clamped(logic [TIME_WIDTH-1:0] base,
			logic [DELAY_W-1:0] offset);
		logic [TIME_WIDTH:0] sum;
		sum = {1'b0, base} + offset;
		return sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
	endfunction

	function automatic release_result_t predict_release(logic op, logic [ID_W-1:0] id,
			logic [DELAY_W-1:0] delay);
		release_result_t r;
		queued_task_t    t;
		int              pos;
		r = '0;
		if (op == OP_ENQUEUE) begin
			if (waiting.size() >= QUEUE_DEPTH) begin
				r.rejected = 1'b1;
			end else begin
				t.deadline = add_clamped(now_ms, delay);
				t.task_id = id;
				// stable: goes behind every task due no later
				pos = waiting.size();
				while (pos > 0 && waiting[pos-1].deadline > t.deadline)
					pos--;
				waiting.insert(pos, t);
			end
		end else begin
			if (waiting.size() > 0 && waiting[0].deadline <= now_ms) begin
				r.released = 1'b1;
				r.task_id = waiting[0].task_id;
				void'(waiting.pop_front());
			end
			now_ms = add_clamped(now_ms, DELAY_W'(step_ms));
		end
		r.count = COUNT_W'(waiting.size());
		return r;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : observe
		release_result_t want;
		if (!arst_n) begin
			now_ms = '0;
			step_ms = STEP_RESET;
			waiting.delete();
			results.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results.size() == 0) begin
					$error("result transfer with no prediction outstanding");
					errors++;
				end else begin
					want = results.pop_front();
					compare_field("released", want.released, m_tuser[0]);
					compare_field("released_task", want.task_id, m_tdata[ID_W-1:0]);
					compare_field("enqueue_rejected", want.rejected, m_tuser[1]);
					compare_field("queued_count", want.count, m_tdata[ID_W+COUNT_W-1:ID_W]);
				end
			end
			if (s_tvalid && s_tready)
				results.push_back(predict_release(s_tuser[0], s_tdata[ID_W-1:0],
					s_tdata[ID_W+DELAY_W-1:ID_W]));
			if (cfg_we)
				step_ms = cfg_wdata;
			outstanding = results.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the deadline task release queue: a directed run over empty
// ticks, equal deadlines and extreme fields, then random phases at several
// tick steps (including zero and the maximum) that fill the queue to
// rejection and drain it again, under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module testbench;
	import dtrq_pkg::*;

	localparam int QUEUE_DEPTH    = 64;
	localparam int TIME_WIDTH     = 48;
	localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 90;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [STEP_W-1:0]    cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	int                   errors;
	int                   outstanding;

	logic                 hold_req = 1'b0;
	logic                 hold_done = 1'b0;
	int                   burst_left = 0;

	deadline_task_release_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TIME_WIDTH (TIME_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	release_queue_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(input logic op, input logic [ID_W-1:0] id,
			input logic [DELAY_W-1:0] delay);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {delay, id};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [STEP_W-1:0] step, input int enqueue_pct,
			input bit with_hold);
		int unsigned span;
		int          sel;
		logic        op;
		logic [DELAY_W-1:0] delay;
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= step;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (with_hold)
			hold_req = 1'b1;
		span = (step == 0) ? 64 : 32'(step) * 40;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			op = ($urandom_range(0, 99) < enqueue_pct) ? OP_ENQUEUE : OP_TICK;
			sel = $urandom_range(0, 99);
			if (sel < 5)
				delay = '0;
			else if (sel < 8)
				delay = '1;
			else if (sel < 11)
				delay = $urandom;
			else
				delay = $urandom_range(0, span);
			send_item(op, ID_W'($urandom), delay);
		end
	endtask

	// output side: runs of ready, stall and coin-flip, plus one long hold-off
	initial begin : rx_pattern
		int run;
		int style;
		forever begin
			if (hold_req && !hold_done) begin
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
				hold_done = 1'b1;
			end
			run = $urandom_range(1, 24);
			style = $urandom_range(0, 3);
			for (int i = 0; i < run; i++) begin
				@(negedge clk);
				case (style)
					0, 1: m_tready <= 1'b1;
					2: m_tready <= 1'b0;
					default: m_tready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, at the reset step of 100
		send_item(OP_TICK, '1, '1);               // empty queue, time still moves
		send_item(OP_ENQUEUE, 16'hFFFF, '0);      // due at once
		send_item(OP_ENQUEUE, 16'h0000, '1);      // furthest deadline
		send_item(OP_ENQUEUE, 16'h1234, '0);      // same deadline, goes behind
		send_item(OP_ENQUEUE, 16'h00AA, 32'd50);
		send_item(OP_ENQUEUE, 16'h00BB, '0);      // walks past two later tasks
		send_item(OP_ENQUEUE, 16'h5A5A, 32'd100);
		send_item(OP_TICK, '0, '0);
		send_item(OP_TICK, '0, '0);
		send_item(OP_TICK, '0, '0);
		send_item(OP_TICK, '0, '0);
		send_item(OP_TICK, '0, '0);
		send_item(OP_TICK, '0, '0);
		send_item(OP_TICK, '0, '0);               // only the far task is left
		send_item(OP_ENQUEUE, 16'hA5A5, 32'hAAAA_AAAA);
		send_item(OP_ENQUEUE, 16'h5555, 32'h5555_5555);

		// time saturation is out of reach here: it needs about 2^32 ticks
		run_phase(16'd1, 90, 1'b1);               // fills up and rejects
		run_phase(16'hFFFF, 15, 1'b0);            // drains
		run_phase(16'd0, 50, 1'b0);               // time frozen
		run_phase(STEP_W'($urandom_range(2, 65534)), 50, 1'b0);
		run_phase(16'd1, 55, 1'b0);
		run_phase(STEP_W'($urandom_range(2, 65534)), 40, 1'b0);

		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dtrq_pkg.sv
rtl/dtrq_ctrl.sv
rtl/dtrq_dpath.sv
rtl/deadline_task_release_queue.sv
sim/release_queue_checker.sv
sim/testbench.sv
